// ===== design/lee_pkg.sv =====
// Package for the segment endpoint editor: sizes, mode codes, payload types
// and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
package lee_pkg;

  localparam int COORD_BITS = 32;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int DIV_STEPS  = PROD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   wide_t;

  typedef enum logic [2:0] {
    MODE_TOP  = 3'd0,
    MODE_HMID = 3'd1,
    MODE_BOT  = 3'd2,
    MODE_LEFT = 3'd3,
    MODE_VMID = 3'd4,
    MODE_RGT  = 3'd5,
    MODE_EXT1 = 3'd6,
    MODE_EXT2 = 3'd7
  } mode_t;

  localparam logic [1:0] MOVED_NONE  = 2'd0;
  localparam logic [1:0] MOVED_START = 2'd1;
  localparam logic [1:0] MOVED_END   = 2'd2;

  typedef struct packed {
    logic   ovf;
    coord_t val;
  } sat_t;

  function automatic diff_t sdiff(coord_t a, coord_t b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic mag_t mag_of(diff_t v);
    diff_t n;
    n = v[COORD_BITS] ? -v : v;
    return n[COORD_BITS-1:0];
  endfunction

  function automatic wide_t widen(coord_t a);
    return {{(SUM_BITS-COORD_BITS){a[COORD_BITS-1]}}, a};
  endfunction

  // clamp to the coordinate range
  function automatic sat_t sat_c(wide_t v);
    sat_t r;
    if (&v[SUM_BITS-1:COORD_BITS-1] || ~|v[SUM_BITS-1:COORD_BITS-1]) begin
      r.ovf = 1'b0;
      r.val = v[COORD_BITS-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[SUM_BITS-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                            : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // (a+b)/2 rounding toward minus infinity
  function automatic coord_t half_sum(coord_t a, coord_t b);
    diff_t s;
    s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    return s[COORD_BITS:1];
  endfunction

endpackage

// ===== design/lee_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses lee_pkg. Payload only; the caller carries valid bits alongside.
`timescale 1ns / 1ps
module lee_div (
  input  logic          clk,
  input  logic          en,
  input  lee_pkg::prod_t num,
  input  lee_pkg::mag_t  den,
  output lee_pkg::prod_t quo
);
  import lee_pkg::*;

  mag_t  rem_r [1:DIV_STEPS];
  prod_t nq_r  [1:DIV_STEPS];
  mag_t  den_r [1:DIV_STEPS];

  mag_t  rem_w [0:DIV_STEPS];
  prod_t nq_w  [0:DIV_STEPS];
  mag_t  den_w [0:DIV_STEPS];

  assign rem_w[0] = '0;
  assign nq_w[0]  = num;
  assign den_w[0] = den;

  genvar i;
  generate
    for (i = 0; i < DIV_STEPS; i++) begin : g_step
      logic [COORD_BITS:0]   cat;
      logic [COORD_BITS+1:0] dif;
      logic                  ge;
      mag_t                  rem_nxt;

      // nq holds the unused dividend bits on top and quotient bits below
      assign cat     = {rem_w[i], nq_w[i][PROD_BITS-1]};
      assign dif     = {1'b0, cat} - {2'b00, den_w[i]};
      assign ge      = ~dif[COORD_BITS+1];
      assign rem_nxt = ge ? dif[COORD_BITS-1:0] : cat[COORD_BITS-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= rem_nxt;
          nq_r[i+1]  <= {nq_w[i][PROD_BITS-2:0], ge};
          den_r[i+1] <= den_w[i];
        end
      end

      assign rem_w[i+1] = rem_r[i+1];
      assign nq_w[i+1]  = nq_r[i+1];
      assign den_w[i+1] = den_r[i+1];
    end
  endgenerate

  assign quo = nq_r[DIV_STEPS];

endmodule

// ===== design/line_endpoint_edit_top.sv =====
// An accepted item passes stage 1, the product stage, the divider stages, the post stages and the output register.
// Throughput: one item per cycle while the pipeline is not held; the two 64-stage dividers and the
// squaring stages each take a new operand every cycle that the pipeline is not held.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module line_endpoint_edit_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_mode,
  input  lee_pkg::coord_t     in_start_x,
  input  lee_pkg::coord_t     in_start_y,
  input  lee_pkg::coord_t     in_end_x,
  input  lee_pkg::coord_t     in_end_y,
  input  lee_pkg::coord_t     in_target_x,
  input  lee_pkg::coord_t     in_target_y,
  output logic                out_valid,
  input  logic                out_stall,
  output lee_pkg::coord_t     out_new_start_x,
  output lee_pkg::coord_t     out_new_start_y,
  output lee_pkg::coord_t     out_new_end_x,
  output lee_pkg::coord_t     out_new_end_y,
  output logic [1:0]          out_moved_end,
  output logic                out_overflow
);
  import lee_pkg::*;

  localparam int POST_STAGES = 7;

  typedef struct packed {
    mode_t  mode;
    coord_t sx, sy, ex, ey, tx, ty;
    logic   neg_x, neg_y, zx, zy;
  } pre_t;

  typedef struct packed {
    mode_t  mode;
    coord_t sx, sy, ex, ey, tx, ty;
    coord_t pxx, pxy, pyx, pyy, cx, cy;
    logic   ox, oy, ovf, mv_start;
    mag_t   m0, m1, m2, m3;
    prod_t  q0, q1, q2, q3;
  } post_t;

  logic en;
  logic out_valid_r;
  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  // stage 1: differences and their magnitudes
  logic v1_r;
  pre_t s1_r, s1_nxt;
  mag_t mdx_r, mdy_r, mtx_r, mty_r;
  diff_t ddx, ddy, dtx, dty;

  always_comb begin
    ddx = sdiff(in_end_x, in_start_x);
    ddy = sdiff(in_end_y, in_start_y);
    dtx = sdiff(in_target_x, in_start_x);
    dty = sdiff(in_target_y, in_start_y);
    s1_nxt.mode  = mode_t'(in_mode);
    s1_nxt.sx    = in_start_x;
    s1_nxt.sy    = in_start_y;
    s1_nxt.ex    = in_end_x;
    s1_nxt.ey    = in_end_y;
    s1_nxt.tx    = in_target_x;
    s1_nxt.ty    = in_target_y;
    s1_nxt.neg_x = ddy[COORD_BITS] ^ dtx[COORD_BITS] ^ ddx[COORD_BITS];
    s1_nxt.neg_y = ddx[COORD_BITS] ^ dty[COORD_BITS] ^ ddy[COORD_BITS];
    s1_nxt.zx    = (ddx == '0);
    s1_nxt.zy    = (ddy == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      mdx_r <= mag_of(ddx);
      mdy_r <= mag_of(ddy);
      mtx_r <= mag_of(dtx);
      mty_r <= mag_of(dty);
    end
  end

  // stage 2: products, then the divider chain with side data alongside
  prod_t prodx_r, prody_r;
  mag_t  denx_r, deny_r;
  pre_t  pre_r [0:DIV_STEPS];
  logic  [DIV_STEPS:0] vpre_r;
  prod_t qx_mag, qy_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      prodx_r  <= mdy_r * mtx_r;
      prody_r  <= mdx_r * mty_r;
      denx_r   <= mdx_r;
      deny_r   <= mdy_r;
      pre_r[0] <= s1_r;
      for (int k = 1; k <= DIV_STEPS; k++) pre_r[k] <= pre_r[k-1];
    end
  end

  lee_div u_div_x (.clk(clk), .en(en), .num(prodx_r), .den(denx_r), .quo(qx_mag));
  lee_div u_div_y (.clk(clk), .en(en), .num(prody_r), .den(deny_r), .quo(qy_mag));

  // post stages: 0 projection, 1-3 target distances, 4-6 endpoint distances
  post_t post_r [0:POST_STAGES-1];
  post_t p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt, p5_nxt, p6_nxt;
  logic  [POST_STAGES-1:0] vpost_r;
  pre_t  pd;
  wide_t qx, qy;
  sat_t  sx_sat, sy_sat;
  logic  [PROD_BITS:0] dpx, dpy, dst, den_d;

  always_comb begin
    pd = pre_r[DIV_STEPS];
    qx = pd.neg_x ? -wide_t'({2'b00, qx_mag}) : wide_t'({2'b00, qx_mag});
    qy = pd.neg_y ? -wide_t'({2'b00, qy_mag}) : wide_t'({2'b00, qy_mag});
    sx_sat = sat_c(widen(pd.sy) + qx);
    sy_sat = sat_c(widen(pd.sx) + qy);

    p0_nxt      = '0;
    p0_nxt.mode = pd.mode;
    p0_nxt.sx   = pd.sx;
    p0_nxt.sy   = pd.sy;
    p0_nxt.ex   = pd.ex;
    p0_nxt.ey   = pd.ey;
    p0_nxt.tx   = pd.tx;
    p0_nxt.ty   = pd.ty;
    // vertical segment: projection along x lands on (start_x, target_y)
    if (pd.zx) begin
      p0_nxt.pxx = pd.sx;
      p0_nxt.pxy = pd.ty;
      p0_nxt.ox  = 1'b0;
    end else begin
      p0_nxt.pxx = pd.tx;
      p0_nxt.pxy = sx_sat.val;
      p0_nxt.ox  = sx_sat.ovf;
    end
    if (pd.zy) begin
      p0_nxt.pyx = pd.tx;
      p0_nxt.pyy = pd.sy;
      p0_nxt.oy  = 1'b0;
    end else begin
      p0_nxt.pyx = sy_sat.val;
      p0_nxt.pyy = pd.ty;
      p0_nxt.oy  = sy_sat.ovf;
    end

    p1_nxt    = post_r[0];
    p1_nxt.m0 = mag_of(sdiff(post_r[0].tx, post_r[0].pxx));
    p1_nxt.m1 = mag_of(sdiff(post_r[0].ty, post_r[0].pxy));
    p1_nxt.m2 = mag_of(sdiff(post_r[0].tx, post_r[0].pyx));
    p1_nxt.m3 = mag_of(sdiff(post_r[0].ty, post_r[0].pyy));

    p2_nxt    = post_r[1];
    p2_nxt.q0 = post_r[1].m0 * post_r[1].m0;
    p2_nxt.q1 = post_r[1].m1 * post_r[1].m1;
    p2_nxt.q2 = post_r[1].m2 * post_r[1].m2;
    p2_nxt.q3 = post_r[1].m3 * post_r[1].m3;

    // ties go to the projection along y
    p3_nxt = post_r[2];
    dpx = {1'b0, post_r[2].q0} + {1'b0, post_r[2].q1};
    dpy = {1'b0, post_r[2].q2} + {1'b0, post_r[2].q3};
    if (dpx < dpy) begin
      p3_nxt.cx  = post_r[2].pxx;
      p3_nxt.cy  = post_r[2].pxy;
      p3_nxt.ovf = post_r[2].ox;
    end else begin
      p3_nxt.cx  = post_r[2].pyx;
      p3_nxt.cy  = post_r[2].pyy;
      p3_nxt.ovf = post_r[2].oy;
    end

    p4_nxt    = post_r[3];
    p4_nxt.m0 = mag_of(sdiff(post_r[3].cx, post_r[3].sx));
    p4_nxt.m1 = mag_of(sdiff(post_r[3].cy, post_r[3].sy));
    p4_nxt.m2 = mag_of(sdiff(post_r[3].cx, post_r[3].ex));
    p4_nxt.m3 = mag_of(sdiff(post_r[3].cy, post_r[3].ey));

    p5_nxt    = post_r[4];
    p5_nxt.q0 = post_r[4].m0 * post_r[4].m0;
    p5_nxt.q1 = post_r[4].m1 * post_r[4].m1;
    p5_nxt.q2 = post_r[4].m2 * post_r[4].m2;
    p5_nxt.q3 = post_r[4].m3 * post_r[4].m3;

    // ties move the end point
    p6_nxt = post_r[5];
    dst   = {1'b0, post_r[5].q0} + {1'b0, post_r[5].q1};
    den_d = {1'b0, post_r[5].q2} + {1'b0, post_r[5].q3};
    p6_nxt.mv_start = (dst < den_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post_r[0] <= p0_nxt;
      post_r[1] <= p1_nxt;
      post_r[2] <= p2_nxt;
      post_r[3] <= p3_nxt;
      post_r[4] <= p4_nxt;
      post_r[5] <= p5_nxt;
      post_r[6] <= p6_nxt;
    end
  end

  // final stage: alignment modes, mirror of the other endpoint, output register
  post_t  f;
  sat_t   mir_x, mir_y;
  coord_t hm;
  coord_t nsx_nxt, nsy_nxt, nex_nxt, ney_nxt;
  logic [1:0] moved_nxt;
  logic   ovf_nxt;

  coord_t nsx_r, nsy_r, nex_r, ney_r;
  logic [1:0] moved_r;
  logic   ovf_r;

  always_comb begin
    f = post_r[POST_STAGES-1];
    mir_x = sat_c(widen(f.sx) + widen(f.ex) - widen(f.cx));
    mir_y = sat_c(widen(f.sy) + widen(f.ey) - widen(f.cy));
    nsx_nxt   = f.sx;
    nsy_nxt   = f.sy;
    nex_nxt   = f.ex;
    ney_nxt   = f.ey;
    moved_nxt = MOVED_NONE;
    ovf_nxt   = 1'b0;
    hm        = '0;
    case (f.mode)
      MODE_TOP: begin
        if ($signed(f.sy) > $signed(f.ey)) ney_nxt = f.sy;
        else if ($signed(f.sy) < $signed(f.ey)) nsy_nxt = f.ey;
      end
      MODE_HMID: begin
        hm = half_sum(f.sy, f.ey);
        if (f.sy != f.ey) begin
          nsy_nxt = hm;
          ney_nxt = hm;
        end
      end
      MODE_BOT: begin
        if ($signed(f.sy) > $signed(f.ey)) nsy_nxt = f.ey;
        else if ($signed(f.sy) < $signed(f.ey)) ney_nxt = f.sy;
      end
      MODE_LEFT: begin
        if ($signed(f.sx) < $signed(f.ex)) nex_nxt = f.sx;
        else if ($signed(f.sx) > $signed(f.ex)) nsx_nxt = f.ex;
      end
      MODE_VMID: begin
        hm = half_sum(f.sx, f.ex);
        if (f.sx != f.ex) begin
          nsx_nxt = hm;
          nex_nxt = hm;
        end
      end
      MODE_RGT: begin
        if ($signed(f.sx) < $signed(f.ex)) nsx_nxt = f.ex;
        else if ($signed(f.sx) > $signed(f.ex)) nex_nxt = f.sx;
      end
      default: begin
        ovf_nxt = f.ovf;
        if (f.mv_start) begin
          moved_nxt = MOVED_START;
          nsx_nxt   = f.cx;
          nsy_nxt   = f.cy;
          if (f.mode == MODE_EXT2) begin
            nex_nxt = mir_x.val;
            ney_nxt = mir_y.val;
            ovf_nxt = f.ovf | mir_x.ovf | mir_y.ovf;
          end
        end else begin
          moved_nxt = MOVED_END;
          nex_nxt   = f.cx;
          ney_nxt   = f.cy;
          if (f.mode == MODE_EXT2) begin
            nsx_nxt = mir_x.val;
            nsy_nxt = mir_y.val;
            ovf_nxt = f.ovf | mir_x.ovf | mir_y.ovf;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nsx_r   <= nsx_nxt;
      nsy_r   <= nsy_nxt;
      nex_r   <= nex_nxt;
      ney_r   <= ney_nxt;
      moved_r <= moved_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      vpre_r      <= '0;
      vpost_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      vpre_r      <= {vpre_r[DIV_STEPS-1:0], v1_r};
      vpost_r     <= {vpost_r[POST_STAGES-2:0], vpre_r[DIV_STEPS]};
      out_valid_r <= vpost_r[POST_STAGES-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_start_x = nsx_r;
  assign out_new_start_y = nsy_r;
  assign out_new_end_x   = nex_r;
  assign out_new_end_y   = ney_r;
  assign out_moved_end   = moved_r;
  assign out_overflow    = ovf_r;

endmodule

// ===== design/lee_chk.sv =====
// Port-level checker for line_endpoint_edit_top, bound to the top level.
// Uses lee_pkg for types and codes.
`timescale 1ns / 1ps
module lee_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input lee_pkg::coord_t out_new_start_x,
  input lee_pkg::coord_t out_new_start_y,
  input lee_pkg::coord_t out_new_end_x,
  input lee_pkg::coord_t out_new_end_y,
  input logic [1:0]      out_moved_end,
  input logic            out_overflow
);
  import lee_pkg::*;

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_moved_end != 2'd3)
    else $error("bad moved_end code");

  // an align result is level in x or y and never saturates
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved_end == MOVED_NONE |->
      !out_overflow &&
      (out_new_start_x == out_new_end_x || out_new_start_y == out_new_end_y))
    else $error("align result not level");

endmodule

bind line_endpoint_edit_top lee_chk u_lee_chk (.*);
